// ----- src/mawc_pkg.sv -----
`timescale 1ns / 1ps

package mawc_pkg;

  localparam int WINDOW      = 6;
  localparam int SAMPLE_BITS = 12;

  localparam int RAW_W    = 12;
  localparam int THR_W    = 7;
  localparam int LEVEL_W  = 8;
  localparam int TICKS_W  = 8;
  localparam int PCT_W    = 7;
  localparam int SLOT_W   = $clog2(WINDOW);
  localparam int SUM_W    = $clog2(WINDOW * 255 + 1);
  localparam int QUO_W    = LEVEL_W;
  localparam int NUM_W    = SAMPLE_BITS + PCT_W;
  localparam int REM_W    = SAMPLE_BITS + 1;
  localparam int DCNT_W   = $clog2(QUO_W + 1);
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam int FULL_PCT    = 100;
  localparam int RESET_LEVEL = 100;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  localparam logic [2:0] REG_MAX_READING     = 3'd0;
  localparam logic [2:0] REG_MIN_READING     = 3'd1;
  localparam logic [2:0] REG_WATER_THRESHOLD = 3'd2;
  localparam logic [2:0] REG_REFILL_LEVEL    = 3'd3;
  localparam logic [2:0] REG_WATER_TICKS     = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_PCT,
    ST_UPD,
    ST_MEAN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                   start;
    logic [NUM_W-1:0]       num;
    logic [SAMPLE_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  function automatic logic [SAMPLE_BITS-1:0] to_sample(input logic [RAW_W-1:0] v);
    logic [SAMPLE_BITS+RAW_W-1:0] ext;
    ext = {{SAMPLE_BITS{1'b0}}, v};
    return ext[SAMPLE_BITS-1:0];
  endfunction

endpackage

// ----- src/mawc_div.sv -----
`timescale 1ns / 1ps

module mawc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  mawc_pkg::div_req_t  req,
  output mawc_pkg::div_rsp_t  rsp
);

  logic [mawc_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic [mawc_pkg::QUO_W-1:0]  shf_r, shf_nxt;
  logic [mawc_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;
  logic                        done_r, done_nxt;
  logic [mawc_pkg::REM_W-1:0]  trial;
  logic [mawc_pkg::REM_W-1:0]  den_ext;
  logic                        ge;

  assign den_ext = {1'b0, req.den};
  assign trial   = {rem_r[mawc_pkg::REM_W-2:0], shf_r[mawc_pkg::QUO_W-1]};
  assign ge      = (trial >= den_ext);

  always_comb begin
    rem_nxt  = rem_r;
    shf_nxt  = shf_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt = mawc_pkg::REM_W'(req.num[mawc_pkg::NUM_W-1:mawc_pkg::QUO_W]);
      shf_nxt = req.num[mawc_pkg::QUO_W-1:0];
      cnt_nxt = mawc_pkg::DCNT_W'(mawc_pkg::QUO_W);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? (trial - den_ext) : trial;
      shf_nxt  = {shf_r[mawc_pkg::QUO_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == mawc_pkg::DCNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    shf_r <= shf_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = shf_r;

endmodule

// ----- src/moisture_average_watering_controller_unit.sv -----
`timescale 1ns / 1ps
// A tick or a dropped sample goes from acceptance straight to the output state; a stored
// sample passes prep, the percentage on the 8-step serial divider when needed, ring update and mean.
// Input is taken only in idle, so a new transaction waits until the last result is loaded; the
// shared bit-serial divider runs once or twice per sample (percentage if needed, then ring mean).
// Reset (rst_n, synchronous): registers at defaults, ring at 100, pump off, output empty.

module moisture_average_watering_controller_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_kind,
  input  logic [mawc_pkg::RAW_W-1:0]          in_reading,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mawc_pkg::PCT_W-1:0]          out_moisture,
  output logic [mawc_pkg::LEVEL_W-1:0]        out_mean_level,
  output logic                                out_pump_on,
  output logic                                out_watering_started,
  output logic                                out_sample_dropped,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [mawc_pkg::ADDR_W-1:0]         cfg_paddr,
  input  logic [mawc_pkg::DATA_W-1:0]         cfg_pwdata,
  output logic [mawc_pkg::DATA_W-1:0]         cfg_prdata,
  output logic                                cfg_pready
);

  mawc_pkg::state_t state_r, state_nxt;

  logic [mawc_pkg::RAW_W-1:0]   max_reading_r;
  logic [mawc_pkg::RAW_W-1:0]   min_reading_r;
  logic [mawc_pkg::THR_W-1:0]   water_threshold_r;
  logic [mawc_pkg::LEVEL_W-1:0] refill_level_r;
  logic [mawc_pkg::TICKS_W-1:0] water_ticks_r;

  logic [mawc_pkg::LEVEL_W-1:0] ring_r [mawc_pkg::WINDOW];
  logic [mawc_pkg::SUM_W-1:0]   ring_sum_r;
  logic [mawc_pkg::SLOT_W-1:0]  write_slot_r;
  logic [mawc_pkg::TICKS_W-1:0] pump_remaining_r;
  logic [mawc_pkg::LEVEL_W-1:0] mean_r;

  logic [mawc_pkg::SAMPLE_BITS-1:0] reading_r;
  logic [mawc_pkg::PCT_W-1:0]       pct_r;
  logic                             started_r;
  logic                             dropped_r;
  logic                             out_valid_r;

  logic                             cfg_wr;
  logic [2:0]                       cfg_idx;
  logic                             in_fire;
  logic                             out_load;
  logic [mawc_pkg::SAMPLE_BITS-1:0] hi, lo;
  logic                             pct_zero, pct_full;
  logic [mawc_pkg::SUM_W-1:0]       sum_upd;
  logic [mawc_pkg::SLOT_W-1:0]      slot_adv;
  logic                             water_now;

  mawc_pkg::div_req_t div_req;
  mawc_pkg::div_rsp_t div_rsp;

  mawc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      mawc_pkg::REG_MAX_READING:     cfg_prdata = mawc_pkg::DATA_W'(max_reading_r);
      mawc_pkg::REG_MIN_READING:     cfg_prdata = mawc_pkg::DATA_W'(min_reading_r);
      mawc_pkg::REG_WATER_THRESHOLD: cfg_prdata = mawc_pkg::DATA_W'(water_threshold_r);
      mawc_pkg::REG_REFILL_LEVEL:    cfg_prdata = mawc_pkg::DATA_W'(refill_level_r);
      mawc_pkg::REG_WATER_TICKS:     cfg_prdata = mawc_pkg::DATA_W'(water_ticks_r);
      default:                       cfg_prdata = '0;
    endcase
  end

  assign in_fire = in_valid && in_ready;

  assign hi       = mawc_pkg::to_sample(max_reading_r);
  assign lo       = mawc_pkg::to_sample(min_reading_r);
  assign pct_zero = (hi <= lo) || (reading_r >= hi);
  assign pct_full = (reading_r <= lo);

  assign sum_upd = mawc_pkg::SUM_W'(ring_sum_r - mawc_pkg::SUM_W'(ring_r[write_slot_r])
                   + mawc_pkg::SUM_W'(pct_r));
  assign slot_adv = (write_slot_r == mawc_pkg::SLOT_W'(mawc_pkg::WINDOW - 1)) ?
                    '0 : write_slot_r + 1'b1;
  assign water_now = div_rsp.quo < {1'b0, water_threshold_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mawc_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_kind == mawc_pkg::KIND_TICK || pump_remaining_r != '0) ?
                      mawc_pkg::ST_OUT : mawc_pkg::ST_PREP;
        end
      end
      mawc_pkg::ST_PREP: begin
        state_nxt = (pct_zero || pct_full) ? mawc_pkg::ST_UPD : mawc_pkg::ST_PCT;
      end
      mawc_pkg::ST_PCT: begin
        if (div_rsp.done) state_nxt = mawc_pkg::ST_UPD;
      end
      mawc_pkg::ST_UPD: begin
        state_nxt = mawc_pkg::ST_MEAN;
      end
      mawc_pkg::ST_MEAN: begin
        if (div_rsp.done) state_nxt = mawc_pkg::ST_OUT;
      end
      mawc_pkg::ST_OUT: begin
        if (out_load) state_nxt = mawc_pkg::ST_IDLE;
      end
      default: state_nxt = mawc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    div_req  = '0;
    unique case (state_r)
      mawc_pkg::ST_IDLE: in_ready = 1'b1;
      mawc_pkg::ST_PREP: begin
        div_req.start = !(pct_zero || pct_full);
        div_req.num   = mawc_pkg::NUM_W'(hi - reading_r) *
                        mawc_pkg::NUM_W'(mawc_pkg::FULL_PCT);
        div_req.den   = hi - lo;
      end
      mawc_pkg::ST_UPD: begin
        div_req.start = 1'b1;
        div_req.num   = mawc_pkg::NUM_W'(sum_upd);
        div_req.den   = mawc_pkg::SAMPLE_BITS'(mawc_pkg::WINDOW);
      end
      mawc_pkg::ST_MEAN: div_req.den = mawc_pkg::SAMPLE_BITS'(mawc_pkg::WINDOW);
      mawc_pkg::ST_PCT:  div_req.den = hi - lo;
      mawc_pkg::ST_OUT:  out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= mawc_pkg::ST_IDLE;
      max_reading_r     <= mawc_pkg::RAW_W'(3300);
      min_reading_r     <= mawc_pkg::RAW_W'(1200);
      water_threshold_r <= mawc_pkg::THR_W'(20);
      refill_level_r    <= mawc_pkg::LEVEL_W'(100);
      water_ticks_r     <= mawc_pkg::TICKS_W'(3);
      for (int i = 0; i < mawc_pkg::WINDOW; i++) begin
        ring_r[i] <= mawc_pkg::LEVEL_W'(mawc_pkg::RESET_LEVEL);
      end
      ring_sum_r       <= mawc_pkg::SUM_W'(mawc_pkg::RESET_LEVEL * mawc_pkg::WINDOW);
      write_slot_r     <= '0;
      pump_remaining_r <= '0;
      mean_r           <= mawc_pkg::LEVEL_W'(mawc_pkg::RESET_LEVEL);
      out_valid_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        unique case (cfg_idx)
          mawc_pkg::REG_MAX_READING:     max_reading_r     <= cfg_pwdata[mawc_pkg::RAW_W-1:0];
          mawc_pkg::REG_MIN_READING:     min_reading_r     <= cfg_pwdata[mawc_pkg::RAW_W-1:0];
          mawc_pkg::REG_WATER_THRESHOLD: water_threshold_r <= cfg_pwdata[mawc_pkg::THR_W-1:0];
          mawc_pkg::REG_REFILL_LEVEL:    refill_level_r    <= cfg_pwdata[mawc_pkg::LEVEL_W-1:0];
          mawc_pkg::REG_WATER_TICKS:     water_ticks_r     <= cfg_pwdata[mawc_pkg::TICKS_W-1:0];
          default: ;
        endcase
      end
      // count the pump down on a tick
      if (in_fire && in_kind == mawc_pkg::KIND_TICK && pump_remaining_r != '0) begin
        pump_remaining_r <= pump_remaining_r - 1'b1;
      end
      if (state_r == mawc_pkg::ST_UPD) begin
        ring_r[write_slot_r] <= mawc_pkg::LEVEL_W'(pct_r);
        ring_sum_r           <= sum_upd;
        write_slot_r         <= slot_adv;
      end
      if (state_r == mawc_pkg::ST_MEAN && div_rsp.done) begin
        if (water_now) begin
          for (int i = 0; i < mawc_pkg::WINDOW; i++) begin
            ring_r[i] <= refill_level_r;
          end
          ring_sum_r       <= mawc_pkg::SUM_W'(refill_level_r * mawc_pkg::WINDOW);
          pump_remaining_r <= water_ticks_r;
          mean_r           <= refill_level_r;
        end else begin
          mean_r <= div_rsp.quo;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      reading_r <= mawc_pkg::to_sample(in_reading);
      pct_r     <= '0;
      started_r <= 1'b0;
      dropped_r <= (in_kind == mawc_pkg::KIND_SAMPLE) && (pump_remaining_r != '0);
    end
    if (state_r == mawc_pkg::ST_PREP) begin
      pct_r <= pct_zero ? '0 : mawc_pkg::PCT_W'(mawc_pkg::FULL_PCT);
    end
    if (state_r == mawc_pkg::ST_PCT && div_rsp.done) begin
      pct_r <= div_rsp.quo[mawc_pkg::PCT_W-1:0];
    end
    if (state_r == mawc_pkg::ST_MEAN && div_rsp.done) begin
      started_r <= water_now;
    end
    if (out_load) begin
      out_moisture         <= pct_r;
      out_mean_level       <= mean_r;
      out_pump_on          <= (pump_remaining_r != '0);
      out_watering_started <= started_r;
      out_sample_dropped   <= dropped_r;
    end
  end

  assign out_valid = out_valid_r;

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == mawc_pkg::ST_PCT || state_r == mawc_pkg::ST_MEAN))
    else $error("divider finished outside a wait state");

  a_drop_direct: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_kind == mawc_pkg::KIND_SAMPLE && pump_remaining_r != '0) |=>
      (state_r == mawc_pkg::ST_OUT && dropped_r))
    else $error("sample during watering not flagged as dropped");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    write_slot_r <= mawc_pkg::SLOT_W'(mawc_pkg::WINDOW - 1))
    else $error("write slot beyond ring");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && state_r == mawc_pkg::ST_IDLE))
    else $error("result load did not present output");

  a_tick_keeps_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_kind == mawc_pkg::KIND_TICK) |=>
      $stable(ring_sum_r) && $stable(write_slot_r))
    else $error("tick changed the ring");

endmodule

// ----- test/moisture_watering_checker.sv -----
`timescale 1ns / 1ps

module moisture_watering_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         in_kind,
  input  logic [mawc_pkg::RAW_W-1:0]   in_reading,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [mawc_pkg::PCT_W-1:0]   out_moisture,
  input  logic [mawc_pkg::LEVEL_W-1:0] out_mean_level,
  input  logic                         out_pump_on,
  input  logic                         out_watering_started,
  input  logic                         out_sample_dropped,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [mawc_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [mawc_pkg::DATA_W-1:0]  cfg_pwdata,
  input  logic                         cfg_pready,
  output int                           error_count,
  output int                           report_backlog,
  output int                           watering_count,
  output int                           drop_count
);

  localparam int   DEFAULT_MAX       = 3300;
  localparam int   DEFAULT_MIN       = 1200;
  localparam int   DEFAULT_THRESHOLD = 20;
  localparam int   DEFAULT_REFILL    = 100;
  localparam int   DEFAULT_TICKS     = 3;

  typedef struct packed {
    logic [mawc_pkg::PCT_W-1:0]   moisture;
    logic [mawc_pkg::LEVEL_W-1:0] mean_level;
    logic                         pump_on;
    logic                         watering_started;
    logic                         sample_dropped;
  } moisture_report_t;

  logic [mawc_pkg::RAW_W-1:0]   max_reading_q;
  logic [mawc_pkg::RAW_W-1:0]   min_reading_q;
  logic [mawc_pkg::THR_W-1:0]   threshold_q;
  logic [mawc_pkg::LEVEL_W-1:0] refill_q;
  logic [mawc_pkg::TICKS_W-1:0] ticks_q;

  logic [mawc_pkg::LEVEL_W-1:0] ring_q [mawc_pkg::WINDOW];
  int                           ring_total;
  int                           next_slot;
  logic [mawc_pkg::TICKS_W-1:0] pump_left;

  moisture_report_t   pending_reports [$];

  initial begin
    error_count    = 0;
    report_backlog = 0;
    watering_count = 0;
    drop_count     = 0;
  end

  function automatic int moisture_pct(input logic [mawc_pkg::RAW_W-1:0] raw);
    int hi;
    int lo;
    int pct;
    hi = max_reading_q;
    lo = min_reading_q;
    if (hi <= lo || int'(raw) >= hi) return 0;
    pct = ((hi - int'(raw)) * mawc_pkg::FULL_PCT) / (hi - lo);
    return (pct > mawc_pkg::FULL_PCT) ? mawc_pkg::FULL_PCT : pct;
  endfunction

  function automatic void refill_ring(input int level);
    for (int i = 0; i < mawc_pkg::WINDOW; i++) ring_q[i] = level[mawc_pkg::LEVEL_W-1:0];
    ring_total = level * mawc_pkg::WINDOW;
  endfunction

  function automatic moisture_report_t advance_controller(
      input logic kind, input logic [mawc_pkg::RAW_W-1:0] reading);
    moisture_report_t rpt;
    int pct;
    rpt = '0;
    if (kind == mawc_pkg::KIND_TICK) begin
      if (pump_left != 0) pump_left = pump_left - 1'b1;
    end else if (pump_left != 0) begin
      rpt.sample_dropped = 1'b1;
    end else begin
      pct = moisture_pct(reading);
      ring_total = ring_total - int'(ring_q[next_slot]) + pct;
      ring_q[next_slot] = pct[mawc_pkg::LEVEL_W-1:0];
      next_slot = (next_slot == mawc_pkg::WINDOW - 1) ? 0 : next_slot + 1;
      rpt.moisture = pct[mawc_pkg::PCT_W-1:0];
      if (ring_total / mawc_pkg::WINDOW < int'(threshold_q)) begin
        rpt.watering_started = 1'b1;
        pump_left = ticks_q;
        refill_ring(int'(refill_q));
      end
    end
    rpt.mean_level = mawc_pkg::LEVEL_W'(ring_total / mawc_pkg::WINDOW);
    rpt.pump_on    = (pump_left != 0);
    return rpt;
  endfunction

  always @(posedge clk) begin : watch
    moisture_report_t want;
    if (!rst_n) begin
      max_reading_q = mawc_pkg::RAW_W'(DEFAULT_MAX);
      min_reading_q = mawc_pkg::RAW_W'(DEFAULT_MIN);
      threshold_q   = mawc_pkg::THR_W'(DEFAULT_THRESHOLD);
      refill_q      = mawc_pkg::LEVEL_W'(DEFAULT_REFILL);
      ticks_q       = mawc_pkg::TICKS_W'(DEFAULT_TICKS);
      refill_ring(mawc_pkg::RESET_LEVEL);
      next_slot     = 0;
      pump_left     = '0;
      pending_reports.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[mawc_pkg::ADDR_W-1:2])
          mawc_pkg::REG_MAX_READING:     max_reading_q = cfg_pwdata[mawc_pkg::RAW_W-1:0];
          mawc_pkg::REG_MIN_READING:     min_reading_q = cfg_pwdata[mawc_pkg::RAW_W-1:0];
          mawc_pkg::REG_WATER_THRESHOLD: threshold_q   = cfg_pwdata[mawc_pkg::THR_W-1:0];
          mawc_pkg::REG_REFILL_LEVEL:    refill_q      = cfg_pwdata[mawc_pkg::LEVEL_W-1:0];
          mawc_pkg::REG_WATER_TICKS:     ticks_q       = cfg_pwdata[mawc_pkg::TICKS_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          $error("result transaction with no input transaction waiting");
          error_count++;
        end else begin
          want = pending_reports.pop_front();
          if (out_moisture !== want.moisture) begin
            $error("moisture: expected %0d, actual %0d", want.moisture, out_moisture);
            error_count++;
          end
          if (out_mean_level !== want.mean_level) begin
            $error("mean_level: expected %0d, actual %0d", want.mean_level, out_mean_level);
            error_count++;
          end
          if (out_pump_on !== want.pump_on) begin
            $error("pump_on: expected %0d, actual %0d", want.pump_on, out_pump_on);
            error_count++;
          end
          if (out_watering_started !== want.watering_started) begin
            $error("watering_started: expected %0d, actual %0d",
                   want.watering_started, out_watering_started);
            error_count++;
          end
          if (out_sample_dropped !== want.sample_dropped) begin
            $error("sample_dropped: expected %0d, actual %0d",
                   want.sample_dropped, out_sample_dropped);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        want = advance_controller(in_kind, in_reading);
        if (want.watering_started) watering_count++;
        if (want.sample_dropped) drop_count++;
        pending_reports.push_back(want);
      end
    end
    report_backlog = pending_reports.size();
  end

endmodule

// ----- test/tb_moisture_average_watering_controller_unit.sv -----
`timescale 1ns / 1ps

module tb_moisture_average_watering_controller_unit;

  localparam int   HOLD_CYCLES   = 300;
  localparam int   RANDOM_PHASES = 9;
  localparam int   PHASE_ITEMS   = 187;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic                           in_kind;
  logic [mawc_pkg::RAW_W-1:0]     in_reading;
  logic                           out_valid;
  logic                           out_ready;
  logic [mawc_pkg::PCT_W-1:0]     out_moisture;
  logic [mawc_pkg::LEVEL_W-1:0]   out_mean_level;
  logic                           out_pump_on;
  logic                           out_watering_started;
  logic                           out_sample_dropped;
  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [mawc_pkg::ADDR_W-1:0]    cfg_paddr;
  logic [mawc_pkg::DATA_W-1:0]    cfg_pwdata;
  logic [mawc_pkg::DATA_W-1:0]    cfg_prdata;
  logic                           cfg_pready;

  int error_count;
  int report_backlog;
  int watering_count;
  int drop_count;

  int hold_request = 0;
  int tx_idles     = 1;
  int rx_idles     = 1;
  int items_sent   = 0;
  int ticks_sent   = 0;
  int settings_run = 1;

  moisture_average_watering_controller_unit DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_kind              (in_kind),
    .in_reading           (in_reading),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_moisture         (out_moisture),
    .out_mean_level       (out_mean_level),
    .out_pump_on          (out_pump_on),
    .out_watering_started (out_watering_started),
    .out_sample_dropped   (out_sample_dropped),
    .cfg_psel             (cfg_psel),
    .cfg_penable          (cfg_penable),
    .cfg_pwrite           (cfg_pwrite),
    .cfg_paddr            (cfg_paddr),
    .cfg_pwdata           (cfg_pwdata),
    .cfg_prdata           (cfg_prdata),
    .cfg_pready           (cfg_pready)
  );

  moisture_watering_checker checker_i (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_kind              (in_kind),
    .in_reading           (in_reading),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_moisture         (out_moisture),
    .out_mean_level       (out_mean_level),
    .out_pump_on          (out_pump_on),
    .out_watering_started (out_watering_started),
    .out_sample_dropped   (out_sample_dropped),
    .cfg_psel             (cfg_psel),
    .cfg_penable          (cfg_penable),
    .cfg_pwrite           (cfg_pwrite),
    .cfg_paddr            (cfg_paddr),
    .cfg_pwdata           (cfg_pwdata),
    .cfg_pready           (cfg_pready),
    .error_count          (error_count),
    .report_backlog       (report_backlog),
    .watering_count       (watering_count),
    .drop_count           (drop_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_request = 0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (rx_idles != 0 && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic kind, input logic [mawc_pkg::RAW_W-1:0] reading);
    @(negedge clk);
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_reading <= reading;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (kind == mawc_pkg::KIND_TICK) ticks_sent++;
  endtask

  task automatic pause_input(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (report_backlog != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [mawc_pkg::DATA_W-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic write_setting(input int hi, input int lo, input int thr, input int refill,
                               input int ticks);
    write_reg(mawc_pkg::REG_MAX_READING, ($urandom << mawc_pkg::RAW_W) | hi);
    write_reg(mawc_pkg::REG_MIN_READING, ($urandom << mawc_pkg::RAW_W) | lo);
    write_reg(mawc_pkg::REG_WATER_THRESHOLD, ($urandom << mawc_pkg::THR_W) | thr);
    write_reg(mawc_pkg::REG_REFILL_LEVEL, ($urandom << mawc_pkg::LEVEL_W) | refill);
    write_reg(mawc_pkg::REG_WATER_TICKS, ($urandom << mawc_pkg::TICKS_W) | ticks);
    settings_run++;
  endtask

  function automatic logic [mawc_pkg::RAW_W-1:0] pick_reading(input int hi, input int lo);
    int a;
    int b;
    int v;
    a = (hi < lo) ? hi : lo;
    b = (hi < lo) ? lo : hi;
    case ($urandom_range(0, 9))
      0:       v = $urandom_range(0, 4095);
      1:       v = $urandom_range(0, 1) ? 4095 : 0;
      2:       v = $urandom_range(0, 1) ? hi : lo;
      3, 4:    v = b - int'($urandom_range(0, (b - a) / 4));
      default: v = int'($urandom_range(a, b)) + int'($urandom_range(0, 40)) - 20;
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[mawc_pkg::RAW_W-1:0];
  endfunction

  task automatic send_random(input int count, input int tick_pct, input int hi, input int lo);
    for (int i = 0; i < count; i++) begin
      send_item(($urandom_range(0, 99) < tick_pct) ? mawc_pkg::KIND_TICK
                                                   : mawc_pkg::KIND_SAMPLE,
                pick_reading(hi, lo));
      if (tx_idles != 0 && $urandom_range(0, 5) == 0) pause_input($urandom_range(1, 11));
    end
  endtask

  task automatic random_setting(output int hi, output int lo);
    int thr;
    int refill;
    int ticks;
    case ($urandom_range(0, 9))
      0:       hi = 0;
      1:       hi = 4095;
      default: hi = $urandom_range(1500, 4095);
    endcase
    case ($urandom_range(0, 9))
      0:       lo = 0;
      1:       lo = 4095;
      2:       lo = hi;
      default: lo = $urandom_range(0, 2000);
    endcase
    case ($urandom_range(0, 9))
      0:       thr = 0;
      1:       thr = 127;
      2:       thr = 100;
      default: thr = $urandom_range(0, 60);
    endcase
    case ($urandom_range(0, 9))
      0:       refill = 0;
      1:       refill = 255;
      default: refill = $urandom_range(0, 120);
    endcase
    ticks = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
    write_setting(hi, lo, thr, refill, ticks);
  endtask

  initial begin : stimulus
    int hi;
    int lo;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_kind     = mawc_pkg::KIND_SAMPLE;
    in_reading  = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: saturation both ways, range ends, a watering, drops, pump countdown
    send_item(mawc_pkg::KIND_SAMPLE, 12'd4095);
    send_item(mawc_pkg::KIND_SAMPLE, 12'd0);
    send_item(mawc_pkg::KIND_SAMPLE, 12'd3300);
    send_item(mawc_pkg::KIND_SAMPLE, 12'd1200);
    send_item(mawc_pkg::KIND_SAMPLE, 12'd2250);
    repeat (6) send_item(mawc_pkg::KIND_SAMPLE, 12'd4095);
    send_item(mawc_pkg::KIND_SAMPLE, 12'd2000);
    repeat (4) send_item(mawc_pkg::KIND_TICK, 12'hABC);
    send_item(mawc_pkg::KIND_SAMPLE, 12'd0);
    drain();

    // empty range, all registers at their minimum
    write_setting(0, 0, 0, 0, 0);
    send_item(mawc_pkg::KIND_SAMPLE, 12'd0);
    send_item(mawc_pkg::KIND_SAMPLE, 12'd4095);
    send_item(mawc_pkg::KIND_TICK, 12'h543);
    drain();

    // threshold above refill with zero ticks: every sample waters, pump stays off
    write_setting(4095, 0, 127, 50, 0);
    send_item(mawc_pkg::KIND_SAMPLE, 12'd0);
    send_item(mawc_pkg::KIND_SAMPLE, 12'd4095);
    send_item(mawc_pkg::KIND_SAMPLE, 12'd2048);
    drain();

    write_setting(4095, 4095, 0, 255, 255);
    send_item(mawc_pkg::KIND_SAMPLE, 12'd4095);
    send_item(mawc_pkg::KIND_SAMPLE, 12'd0);
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == RANDOM_PHASES - 1) begin
        tx_idles = 0;
        rx_idles = 0;
      end
      random_setting(hi, lo);
      if (phase == 2) begin
        send_random(40, 30, hi, lo);
        hold_request = 1;
        send_random(PHASE_ITEMS - 40, 30, hi, lo);
      end else begin
        send_random(PHASE_ITEMS, $urandom_range(15, 45), hi, lo);
      end
      drain();
    end

    repeat (30) @(negedge clk);
    $display("Covered %0d transactions (%0d ticks) across %0d register settings.",
             items_sent, ticks_sent, settings_run);
    $display("Predicted %0d waterings and %0d dropped samples.", watering_count, drop_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
